@@ design/hufd_pkg.sv @@
package hufd_pkg;

    localparam logic [7:0]  START_FLAG      = 8'h55;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd256;
    localparam int          TDATA_W         = 48;
    localparam int          TDATA_PAD_W     = 7;

    // Frame parse phases, in arrival order of the bytes of one frame.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD_H = 3'd1,
        PH_CMD_L = 3'd2,
        PH_LEN_H = 3'd3,
        PH_LEN_L = 3'd4,
        PH_CSUM  = 3'd5,
        PH_DATA  = 3'd6,
        PH_END   = 3'd7
    } phase_t;

    // One result from the parser to the output stage.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] command_code;
        logic        checksum_ok;
        logic        frame_done;
        logic        data_valid;
        logic [7:0]  data_byte;
    } result_t;

endpackage

@@ design/hufd_parser.sv @@
module hufd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output hufd_pkg::result_t   res
);

    hufd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] max_len_reg;
    logic [15:0] command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  csum_reg, csum_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] len_full;

    assign len_full = {length_reg[15:8], rx_byte};

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            unique case (phase_reg)
                hufd_pkg::PH_HUNT: begin
                    if (rx_byte == hufd_pkg::START_FLAG) phase_next = hufd_pkg::PH_CMD_H;
                end
                hufd_pkg::PH_CMD_H: phase_next = hufd_pkg::PH_CMD_L;
                hufd_pkg::PH_CMD_L: phase_next = hufd_pkg::PH_LEN_H;
                hufd_pkg::PH_LEN_H: phase_next = hufd_pkg::PH_LEN_L;
                hufd_pkg::PH_LEN_L: begin
                    phase_next = (len_full > max_len_reg) ? hufd_pkg::PH_HUNT
                                                          : hufd_pkg::PH_CSUM;
                end
                hufd_pkg::PH_CSUM: begin
                    phase_next = (length_reg == 16'd0) ? hufd_pkg::PH_END
                                                       : hufd_pkg::PH_DATA;
                end
                hufd_pkg::PH_DATA: begin
                    if (left_reg == 16'd1) phase_next = hufd_pkg::PH_END;
                end
                hufd_pkg::PH_END: phase_next = hufd_pkg::PH_HUNT;
            endcase
        end
    end

    // Header fields, checksum and byte count
    always_comb begin
        command_next = command_reg;
        length_next  = length_reg;
        csum_next    = csum_reg;
        xor_next     = xor_reg;
        left_next    = left_reg;
        if (in_fire) begin
            unique case (phase_reg)
                hufd_pkg::PH_HUNT: begin
                    if (rx_byte == hufd_pkg::START_FLAG) xor_next = 8'h00;
                end
                hufd_pkg::PH_CMD_H: begin
                    command_next = {rx_byte, 8'h00};
                    xor_next     = xor_reg ^ rx_byte;
                end
                hufd_pkg::PH_CMD_L: begin
                    command_next = {command_reg[15:8], rx_byte};
                    xor_next     = xor_reg ^ rx_byte;
                end
                hufd_pkg::PH_LEN_H: begin
                    length_next = {rx_byte, 8'h00};
                    xor_next    = xor_reg ^ rx_byte;
                end
                hufd_pkg::PH_LEN_L: begin
                    length_next = len_full;
                    xor_next    = xor_reg ^ rx_byte;
                end
                hufd_pkg::PH_CSUM: begin
                    csum_next = rx_byte;
                    left_next = length_reg;
                end
                hufd_pkg::PH_DATA: begin
                    xor_next  = xor_reg ^ rx_byte;
                    left_next = left_reg - 16'd1;
                end
                hufd_pkg::PH_END: ;
            endcase
        end
    end

    // Result for payload and end-flag bytes
    always_comb begin
        res_valid          = in_fire && ((phase_reg == hufd_pkg::PH_DATA) ||
                                         (phase_reg == hufd_pkg::PH_END));
        res.data_valid     = (phase_reg == hufd_pkg::PH_DATA);
        res.data_byte      = (phase_reg == hufd_pkg::PH_DATA) ? rx_byte : 8'h00;
        res.frame_done     = (phase_reg == hufd_pkg::PH_END);
        res.checksum_ok    = (phase_reg == hufd_pkg::PH_END) && (xor_reg == csum_reg);
        res.command_code   = command_reg;
        res.frame_length   = length_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hufd_pkg::PH_HUNT;
            max_len_reg <= hufd_pkg::MAX_LEN_RESET;
            command_reg <= 16'd0;
            length_reg  <= 16'd0;
            csum_reg    <= 8'd0;
            xor_reg     <= 8'd0;
            left_reg    <= 16'd0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            csum_reg    <= csum_next;
            xor_reg     <= xor_next;
            left_reg    <= left_next;
            if (cfg_wr_en) max_len_reg <= cfg_wr_data;
        end
    end

    a_data_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hufd_pkg::PH_DATA) |-> (left_reg != 16'd0))
        else $error("payload phase with no bytes left");

    a_last_data_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (phase_reg == hufd_pkg::PH_DATA) && (left_reg == 16'd1))
        |=> (phase_reg == hufd_pkg::PH_END))
        else $error("last payload byte did not lead to end flag");

    a_len_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (phase_reg == hufd_pkg::PH_LEN_L) && (len_full > max_len_reg))
        |=> (phase_reg == hufd_pkg::PH_HUNT))
        else $error("oversize length not dropped");

endmodule

@@ design/hufd_out_buf.sv @@
module hufd_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hufd_pkg::result_t   push_data,
    output logic                ready,
    output logic                out_valid,
    output hufd_pkg::result_t   out_data,
    input  logic                out_ready
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    hufd_pkg::result_t main_reg, main_next;
    hufd_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // upstream is held off; drain the skid into the output register
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("result pushed while both stages are full");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !out_ready) |=> (main_valid_reg && $stable(main_reg)))
        else $error("stalled result changed");

endmodule

@@ design/hci_uart_frame_deframer.sv @@
// Frame deframer for an XOR-checksummed byte stream from a UART receiver.
// Each transfer on the s_ side carries one received byte. The block hunts for
// the start flag 0x55, then reads a 16-bit command and a 16-bit payload length
// (both high byte first) and one checksum byte. A length above the length
// limit (written through cfg_wr_en/cfg_wr_data, 256 after reset) drops the
// header and hunting resumes with the next byte. Every payload byte gives one
// m_ transfer with m_tuser high; the byte after the payload is the end flag,
// taken without a check, and gives one m_ transfer with m_tlast high and
// checksum_ok telling whether the XOR of the command, length and payload bytes
// matches the checksum. Header bytes, the checksum byte and hunted bytes give
// no transfer. Rate: one byte per clock while s_tready is high. The parse
// state updates in the same cycle as the byte is accepted; a two-entry
// output stage (result register plus skid register) decouples the sides,
// so s_tready drops only when both entries are held by a stalled m_ side.
// Write the configuration only while the block is idle.
module hci_uart_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // length limit

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [8] checksum_ok, [24:9] command_code,
    // [40:25] frame_length, [47:41] zero
    output logic [hufd_pkg::TDATA_W-1:0] m_tdata,
    output logic        m_tuser,       // [0] data_valid
    output logic        m_tlast        // frame_done
);

    logic              in_fire;
    logic              res_valid;
    hufd_pkg::result_t res;
    hufd_pkg::result_t out_res;

    // A byte transfer completes when s_tvalid is high and the output stage has a free entry.
    assign in_fire = s_tvalid && s_tready;

    hufd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .rx_byte     (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    hufd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {{hufd_pkg::TDATA_PAD_W{1'b0}}, out_res.frame_length,
                      out_res.command_code, out_res.checksum_ok, out_res.data_byte};
    assign m_tuser = out_res.data_valid;
    assign m_tlast = out_res.frame_done;

endmodule

@@ test/tb.sv @@
module tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_BYTES = 180;

    // Parse-state mirror of the deframer plus the queue of results it owes.
    class frame_scoreboard;
        hufd_pkg::phase_t  ph;
        logic [15:0]       cmd;
        logic [15:0]       len;
        logic [15:0]       left;
        logic [15:0]       max_len;
        logic [7:0]        csum;
        logic [7:0]        sum;
        hufd_pkg::result_t due_results[$];
        int                errors;

        function new();
            ph = hufd_pkg::PH_HUNT;
            cmd = '0;
            len = '0;
            left = '0;
            max_len = hufd_pkg::MAX_LEN_RESET;
            csum = '0;
            sum = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Advance the parse by one accepted byte; queue the result it causes.
        function void parse_rx_byte(logic [7:0] b);
            hufd_pkg::result_t r;
            r = '0;
            case (ph)
                hufd_pkg::PH_HUNT: begin
                    if (b == hufd_pkg::START_FLAG) begin
                        sum = '0;
                        ph = hufd_pkg::PH_CMD_H;
                    end
                end
                hufd_pkg::PH_CMD_H: begin
                    cmd = {b, 8'h00};
                    sum ^= b;
                    ph = hufd_pkg::PH_CMD_L;
                end
                hufd_pkg::PH_CMD_L: begin
                    cmd = {cmd[15:8], b};
                    sum ^= b;
                    ph = hufd_pkg::PH_LEN_H;
                end
                hufd_pkg::PH_LEN_H: begin
                    len = {b, 8'h00};
                    sum ^= b;
                    ph = hufd_pkg::PH_LEN_L;
                end
                hufd_pkg::PH_LEN_L: begin
                    len = {len[15:8], b};
                    sum ^= b;
                    ph = (len > max_len) ? hufd_pkg::PH_HUNT : hufd_pkg::PH_CSUM;
                end
                hufd_pkg::PH_CSUM: begin
                    csum = b;
                    left = len;
                    ph = (left == 16'd0) ? hufd_pkg::PH_END : hufd_pkg::PH_DATA;
                end
                hufd_pkg::PH_DATA: begin
                    sum ^= b;
                    left = left - 16'd1;
                    if (left == 16'd0)
                        ph = hufd_pkg::PH_END;
                    r.data_byte = b;
                    r.data_valid = 1'b1;
                    r.command_code = cmd;
                    r.frame_length = len;
                    due_results.push_back(r);
                end
                default: begin
                    ph = hufd_pkg::PH_HUNT;
                    r.frame_done = 1'b1;
                    r.checksum_ok = (sum == csum);
                    r.command_code = cmd;
                    r.frame_length = len;
                    due_results.push_back(r);
                end
            endcase
        endfunction

        task check_result(logic [hufd_pkg::TDATA_W-1:0] data, logic user, logic last);
            hufd_pkg::result_t e;
            if (due_results.size() == 0) begin
                report($sformatf("result with none due, tdata %h", data));
                return;
            end
            e = due_results.pop_front();
            if (data[7:0] !== e.data_byte)
                report($sformatf("data_byte %h, want %h", data[7:0], e.data_byte));
            if (data[8] !== e.checksum_ok)
                report($sformatf("checksum_ok %b, want %b", data[8], e.checksum_ok));
            if (data[24:9] !== e.command_code)
                report($sformatf("command_code %h, want %h", data[24:9], e.command_code));
            if (data[40:25] !== e.frame_length)
                report($sformatf("frame_length %h, want %h",
                                 data[40:25], e.frame_length));
            if (data[47:41] !== '0)
                report($sformatf("pad bits %h not zero", data[47:41]));
            if (user !== e.data_valid)
                report($sformatf("data_valid %b, want %b", user, e.data_valid));
            if (last !== e.frame_done)
                report($sformatf("frame_done %b, want %b", last, e.frame_done));
        endtask
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [15:0]                  cfg_wr_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [hufd_pkg::TDATA_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    frame_scoreboard sb = new();
    bit quiet = 1'b0;      // set for the closing stretch: no gaps, no stalls
    int bytes_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    hci_uart_frame_deframer uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Receiver side: at random, hold m_tready low for a stall of random length,
    // otherwise keep it high. The stall counter holds what is left of the stall.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= int'($urandom_range(0, 9));
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Transfer one byte on the s_ side. A gap of random length lowers tvalid
    // first; otherwise tvalid stays high straight from the last byte.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.parse_rx_byte(b);
        bytes_sent++;
    endtask

    // Send one frame with random content, preceded by a little hunt noise.
    // Most frames are well formed; some carry a bad checksum, some announce a
    // length above the limit and stop after the length bytes, as the block expects.
    task automatic send_frame(input logic [15:0] limit);
        logic [15:0] cmd;
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [7:0]  payload[$];
        int          pick;
        repeat ($urandom_range(0, 2)) begin
            b = 8'($urandom);
            // keep noise from opening a frame of its own
            if (b == hufd_pkg::START_FLAG)
                b ^= 8'h01;
            send_byte(b);
        end
        cmd = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0 && limit != 16'hFFFF)
            len = 16'($urandom_range(limit + 1, 65535));
        else if (pick == 1 && limit <= 16)
            len = limit;
        else
            len = 16'($urandom_range(0, (limit < 12) ? limit : 12));
        send_byte(hufd_pkg::START_FLAG);
        send_byte(cmd[15:8]);
        send_byte(cmd[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len > limit)
            return;
        sum = cmd[15:8] ^ cmd[7:0] ^ len[15:8] ^ len[7:0];
        repeat (len) begin
            b = 8'($urandom);
            payload.push_back(b);
            sum ^= b;
        end
        if ($urandom_range(0, 5) == 0)
            sum ^= 8'($urandom_range(1, 255));
        send_byte(sum);
        foreach (payload[i])
            send_byte(payload[i]);
        // end flag: any value, the block does not check it
        send_byte(8'($urandom));
    endtask

    // Write the length limit once the block has drained: s_tvalid is held low
    // and the write waits until no result is still due.
    task automatic write_max_len(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.max_len = v;
    endtask

    initial begin
        logic [15:0] limits[6];
        int          mark;
        limits = '{16'd0, 16'hFFFF, 16'd7, 16'd0, 16'd256, 16'd12};
        limits[3] = 16'($urandom_range(1, 40));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, limit at its reset value of 256.
        // Hunt noise with all bits low and all bits high.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Zero-length frame with a good checksum: end flag follows at once.
        send_byte(hufd_pkg::START_FLAG);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h12 ^ 8'h34);
        send_byte(8'hAA);
        // Length 257 over the limit: header dropped after the low length byte.
        send_byte(hufd_pkg::START_FLAG);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h01);
        // Hunting resumes right away: a start flag at the very next byte,
        // then a two-byte frame whose checksum is wrong.
        send_byte(hufd_pkg::START_FLAG);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7E);

        // Random phases, each under its own length limit; the last runs
        // without gaps or stalls.
        foreach (limits[p]) begin
            write_max_len(limits[p]);
            if (p == $size(limits) - 1)
                quiet = 1'b1;
            mark = bytes_sent;
            while (bytes_sent < mark + PHASE_BYTES)
                send_frame(limits[p]);
        end
        s_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/hufd_pkg.sv
design/hufd_parser.sv
design/hufd_out_buf.sv
design/hci_uart_frame_deframer.sv
test/tb.sv
